// ===== hw/rtl/cis_pkg.sv =====
// Shared types, widths and the reciprocal table of the controller input smoother.
package cis_pkg;

    // Field widths fixed by the report and result formats.
    localparam int SAMPLE_W    = 16;
    localparam int AXIS_FIELDS = 4;
    localparam int BTN_FIELDS  = 5;
    localparam int CNT_W       = 3;
    localparam int REL_W       = 16;

    // Default configuration of the top level.
    localparam int WINDOW_DEF      = 5;
    localparam int NUM_AXES_DEF    = 4;
    localparam int NUM_BUTTONS_DEF = 5;

    // Reciprocal scaling: floor(x * ceil(2^K / n) / 2^K) equals floor(x / n)
    // for x below 2^20 and n up to 16, which covers every window sum magnitude.
    localparam int RECIP_K = 25;
    localparam int RECIP_W = 26;
    localparam int FILL_IDX_W = 5;
    localparam int QUO_W   = 17;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_LOAD
    } t_state;

    // Step strobes sent from the sequencer to every axis lane.
    typedef struct packed {
        logic start;
        logic sum_en;
        logic mul_en;
    } t_lane_ctl;

    // Rounded-up reciprocal of a fill count; an empty window maps to zero.
    function automatic logic [RECIP_W-1:0] recip(input logic [FILL_IDX_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            5'd1:    r = 26'd33554432;
            5'd2:    r = 26'd16777216;
            5'd3:    r = 26'd11184811;
            5'd4:    r = 26'd8388608;
            5'd5:    r = 26'd6710887;
            5'd6:    r = 26'd5592406;
            5'd7:    r = 26'd4793491;
            5'd8:    r = 26'd4194304;
            5'd9:    r = 26'd3728271;
            5'd10:   r = 26'd3355444;
            5'd11:   r = 26'd3050403;
            5'd12:   r = 26'd2796203;
            5'd13:   r = 26'd2581111;
            5'd14:   r = 26'd2396746;
            5'd15:   r = 26'd2236963;
            5'd16:   r = 26'd2097152;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/controller_input_smoother.sv =====
// Top level of the controller input smoother: sequencer, lanes and result register.
//
//   channel   direction  handshake           fields
//   report    in         i_valid / o_stall   i_axis_0..3, i_axis_count, i_button_bits,
//                                            i_button_count
//   result    out        o_valid / i_stall   o_mean_0..3, o_held_mask, o_releases_0..4
//
// The accepting edge reads the window; the running-sum update, the reciprocal
// multiply and the result load follow in that order, each a sequencer state.
// The next report is accepted at the edge after the load, so no report is
// taken while the previous one is still in work.
// Reset clears fill counts, write pointers, sums and button state at once.
// A result that waits on i_stall holds the next report's result in the load
// step, and o_stall stays high until it is taken.
module controller_input_smoother #(
    parameter int WINDOW      = cis_pkg::WINDOW_DEF,
    parameter int NUM_AXES    = cis_pkg::NUM_AXES_DEF,
    parameter int NUM_BUTTONS = cis_pkg::NUM_BUTTONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [cis_pkg::SAMPLE_W-1:0] i_axis_0,
    input  logic signed [cis_pkg::SAMPLE_W-1:0] i_axis_1,
    input  logic signed [cis_pkg::SAMPLE_W-1:0] i_axis_2,
    input  logic signed [cis_pkg::SAMPLE_W-1:0] i_axis_3,
    input  logic [cis_pkg::CNT_W-1:0]           i_axis_count,
    input  logic [cis_pkg::BTN_FIELDS-1:0]      i_button_bits,
    input  logic [cis_pkg::CNT_W-1:0]           i_button_count,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [cis_pkg::SAMPLE_W-1:0] o_mean_0,
    output logic signed [cis_pkg::SAMPLE_W-1:0] o_mean_1,
    output logic signed [cis_pkg::SAMPLE_W-1:0] o_mean_2,
    output logic signed [cis_pkg::SAMPLE_W-1:0] o_mean_3,
    output logic [cis_pkg::BTN_FIELDS-1:0]      o_held_mask,
    output logic [cis_pkg::REL_W-1:0]           o_releases_0,
    output logic [cis_pkg::REL_W-1:0]           o_releases_1,
    output logic [cis_pkg::REL_W-1:0]           o_releases_2,
    output logic [cis_pkg::REL_W-1:0]           o_releases_3,
    output logic [cis_pkg::REL_W-1:0]           o_releases_4
);
    import cis_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_lane_ctl lane_ctl;

    logic in_acc;
    logic out_take;
    logic load;

    logic signed [SAMPLE_W-1:0] w_axis [AXIS_FIELDS];
    logic signed [SAMPLE_W-1:0] w_mean [AXIS_FIELDS];
    logic [BTN_FIELDS-1:0]              w_held;
    logic [BTN_FIELDS-1:0][REL_W-1:0]   w_rel;

    logic                               r_out_valid;
    logic signed [SAMPLE_W-1:0]         r_mean [AXIS_FIELDS];
    logic [BTN_FIELDS-1:0]              r_held;
    logic [BTN_FIELDS-1:0][REL_W-1:0]   r_rel;

    // Handshake terms.
    assign o_stall  = (r_state != ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;
    assign load     = (r_state == ST_LOAD) && (!r_out_valid || !i_stall);

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_SUM;
            ST_SUM:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_LOAD;
            ST_LOAD: if (load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Step strobes for the lanes.
    always_comb begin
        lane_ctl.start  = in_acc;
        lane_ctl.sum_en = (r_state == ST_SUM);
        lane_ctl.mul_en = (r_state == ST_MUL);
    end

    assign w_axis[0] = i_axis_0;
    assign w_axis[1] = i_axis_1;
    assign w_axis[2] = i_axis_2;
    assign w_axis[3] = i_axis_3;

    // Axis lanes; fields past NUM_AXES read as zero.
    for (genvar k = 0; k < AXIS_FIELDS; k++) begin : g_axis
        if (k < NUM_AXES) begin : g_lane
            cis_axis_lane #(
                .WINDOW (WINDOW),
                .LANE   (k)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (lane_ctl),
                .i_sample     (w_axis[k]),
                .i_axis_count (i_axis_count),
                .o_mean       (w_mean[k])
            );
        end else begin : g_none
            assign w_mean[k] = '0;
        end
    end

    cis_buttons #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_buttons (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_bits     (i_button_bits),
        .i_count    (i_button_count),
        .o_held     (w_held),
        .o_releases (w_rel)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Merge the lane results into the result register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < AXIS_FIELDS; k++) begin
                r_mean[k] <= w_mean[k];
            end
            r_held <= w_held;
            r_rel  <= w_rel;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_mean_0     = r_mean[0];
    assign o_mean_1     = r_mean[1];
    assign o_mean_2     = r_mean[2];
    assign o_mean_3     = r_mean[3];
    assign o_held_mask  = r_held;
    assign o_releases_0 = r_rel[0];
    assign o_releases_1 = r_rel[1];
    assign o_releases_2 = r_rel[2];
    assign o_releases_3 = r_rel[3];
    assign o_releases_4 = r_rel[4];

endmodule

// ===== hw/rtl/cis_axis_lane.sv =====
// One axis lane: sample window memory, running sum and reciprocal-multiply mean.
module cis_axis_lane #(
    parameter int WINDOW = cis_pkg::WINDOW_DEF,
    parameter int LANE   = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cis_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [cis_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [cis_pkg::CNT_W-1:0]            i_axis_count,
    output logic signed [cis_pkg::SAMPLE_W-1:0]  o_mean
);
    import cis_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int PROD_W = SUM_W + RECIP_W;

    logic signed [SAMPLE_W-1:0] mem [WINDOW];

    logic [SLOT_W-1:0]          r_slot;
    logic [FILL_W-1:0]          r_fill;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SAMPLE_W-1:0] r_new;
    logic signed [SAMPLE_W-1:0] r_old;
    logic                       r_act;
    logic                       r_full;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_neg;

    logic                       active;
    logic signed [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]           mag;
    logic [RECIP_W-1:0]         rc;
    logic [QUO_W-1:0]           quo;
    logic [QUO_W-1:0]           quo_neg;

    // The lane takes part when its index lies below the report's axis count.
    assign active = i_axis_count > CNT_W'(LANE);

    // Window memory: the old sample is read before the new one replaces it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_old <= mem[r_slot];
            if (active) begin
                mem[r_slot] <= i_sample;
            end
        end
    end

    // Write pointer, fill count and running sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else begin
            if (i_ctl.start && active) begin
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (r_fill != FILL_W'(WINDOW)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_ctl.sum_en && r_act) begin
                r_sum <= n_sum;
            end
        end
    end

    // Beat payload held for the sum step.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_new  <= i_sample;
            r_act  <= active;
            r_full <= (r_fill == FILL_W'(WINDOW));
        end
    end

    // New sample in, oldest sample out once the window is full.
    always_comb begin
        sum_wide = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(r_new)
                 - (r_full ? (SUM_W + 1)'(r_old) : '0);
        n_sum    = SUM_W'(sum_wide);
    end

    // Magnitude times the reciprocal of the fill count.
    assign mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign rc  = recip(FILL_IDX_W'(r_fill));

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(mag) * PROD_W'(rc);
            r_neg  <= r_sum[SUM_W-1];
        end
    end

    // Quotient truncated toward zero, sign restored.
    assign quo     = r_prod[RECIP_K +: QUO_W];
    assign quo_neg = QUO_W'(0) - quo;
    assign o_mean  = r_neg ? SAMPLE_W'(quo_neg) : SAMPLE_W'(quo);

endmodule

// ===== hw/rtl/cis_buttons.sv =====
// Button lanes: edge detection, held flags and wrapping release counters.
module cis_buttons #(
    parameter int NUM_BUTTONS = cis_pkg::NUM_BUTTONS_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_start,
    input  logic [cis_pkg::BTN_FIELDS-1:0]                     i_bits,
    input  logic [cis_pkg::CNT_W-1:0]                          i_count,
    output logic [cis_pkg::BTN_FIELDS-1:0]                     o_held,
    output logic [cis_pkg::BTN_FIELDS-1:0][cis_pkg::REL_W-1:0] o_releases
);
    import cis_pkg::*;

    for (genvar b = 0; b < BTN_FIELDS; b++) begin : g_btn
        if (b < NUM_BUTTONS) begin : g_used
            logic             valid_b;
            logic             rise;
            logic             fall;
            logic             r_last;
            logic             r_held;
            logic [REL_W-1:0] r_rel;

            // Edges are judged only for buttons inside the report's count.
            assign valid_b = i_count > CNT_W'(b);
            assign rise    = valid_b && !r_last && i_bits[b];
            assign fall    = valid_b && r_last && !i_bits[b];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_last <= 1'b0;
                    r_held <= 1'b0;
                    r_rel  <= '0;
                end else if (i_start) begin
                    if (valid_b) begin
                        r_last <= i_bits[b];
                    end
                    if (rise) begin
                        r_held <= 1'b1;
                    end else if (fall) begin
                        r_held <= 1'b0;
                        r_rel  <= r_rel + 1'b1;
                    end
                end
            end

            assign o_held[b]     = r_held;
            assign o_releases[b] = r_rel;
        end else begin : g_unused
            assign o_held[b]     = 1'b0;
            assign o_releases[b] = '0;
        end
    end

endmodule

// ===== hw/rtl/cis_checker.sv =====
// Port-level checks of the controller input smoother and their binding.
module cis_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [cis_pkg::SAMPLE_W-1:0] o_mean_0,
    input logic [cis_pkg::BTN_FIELDS-1:0]      o_held_mask,
    input logic [cis_pkg::REL_W-1:0]           o_releases_0
);
    logic in_acc;

    assign in_acc = i_valid && !o_stall;

    // A stalled result beat stays up with its payload unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mean_0) && $stable(o_held_mask)
                               && $stable(o_releases_0))
        else $error("stalled result beat changed");

    // Once a report is taken, no further report is taken on the next edge.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("report accepted while the previous one is in work");

    // A fresh result beat must follow a report taken through the sum, multiply and load steps.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(in_acc, 4))
        else $error("result beat without a matching report");

    // Held flags change only when the result register is free to reload.
    a_held_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_held_mask) |-> $past(!o_valid || !i_stall))
        else $error("held mask changed while its beat was stalled");

endmodule

bind controller_input_smoother cis_checker u_cis_checker (.*);

// ===== verif/controller_input_smoother_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the controller input smoother: directed reports, then random traffic.
module controller_input_smoother_test;
    import cis_pkg::*;

    localparam int WIN_LEN = WINDOW_DEF;
    localparam int AXES    = NUM_AXES_DEF;
    localparam int BUTTONS = NUM_BUTTONS_DEF;
    localparam int RANDOM_REPORTS = 900;

    // One controller report as it crosses the input channel.
    typedef struct packed {
        logic [AXIS_FIELDS-1:0][SAMPLE_W-1:0] axes;
        logic [CNT_W-1:0]                     axis_count;
        logic [BTN_FIELDS-1:0]                button_bits;
        logic [CNT_W-1:0]                     button_count;
    } t_report;

    // One smoothed result as it leaves the output channel.
    typedef struct packed {
        logic [AXIS_FIELDS-1:0][SAMPLE_W-1:0] means;
        logic [BTN_FIELDS-1:0]                held;
        logic [BTN_FIELDS-1:0][REL_W-1:0]     releases;
    } t_smooth_result;

    // A directed row; the result is typed in only where it is obvious.
    typedef struct packed {
        t_report        rpt;
        logic           typed;
        t_smooth_result want;
    } t_report_row;

    // Receiver back-pressure styles, picked at random during the run.
    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_COIN,
        FLOW_CHOKED,
        FLOW_PERIODIC
    } t_flow_mode;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic signed [SAMPLE_W-1:0]  i_axis_0, i_axis_1, i_axis_2, i_axis_3;
    logic [CNT_W-1:0]            i_axis_count;
    logic [BTN_FIELDS-1:0]       i_button_bits;
    logic [CNT_W-1:0]            i_button_count;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_mean_0, o_mean_1, o_mean_2, o_mean_3;
    logic [BTN_FIELDS-1:0]       o_held_mask;
    logic [REL_W-1:0]            o_releases_0, o_releases_1, o_releases_2;
    logic [REL_W-1:0]            o_releases_3, o_releases_4;

    // Shadow state of the smoother, starting from its reset values.
    logic signed [SAMPLE_W-1:0] window_samples [AXES][WIN_LEN];
    int                         window_fill [AXES] = '{default: 0};
    int                         window_next [AXES] = '{default: 0};
    logic [BTN_FIELDS-1:0]      prev_levels = '0;
    logic [BTN_FIELDS-1:0]      held_flags = '0;
    logic [REL_W-1:0]           release_tally [BUTTONS] = '{default: '0};

    t_smooth_result pending_results [$];
    int             mismatch_count = 0;
    int             burst_left = 0;
    t_flow_mode     flow_mode = FLOW_FREE;
    int             flow_cycles = 0;

    controller_input_smoother dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_axis_0       (i_axis_0),
        .i_axis_1       (i_axis_1),
        .i_axis_2       (i_axis_2),
        .i_axis_3       (i_axis_3),
        .i_axis_count   (i_axis_count),
        .i_button_bits  (i_button_bits),
        .i_button_count (i_button_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mean_0       (o_mean_0),
        .o_mean_1       (o_mean_1),
        .o_mean_2       (o_mean_2),
        .o_mean_3       (o_mean_3),
        .o_held_mask    (o_held_mask),
        .o_releases_0   (o_releases_0),
        .o_releases_1   (o_releases_1),
        .o_releases_2   (o_releases_2),
        .o_releases_3   (o_releases_3),
        .o_releases_4   (o_releases_4)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic t_report make_report(input int a0, input int a1, input int a2,
                                            input int a3, input int n_axes, input int bits,
                                            input int n_btns);
        t_report r;
        r.axes[0]      = SAMPLE_W'(a0);
        r.axes[1]      = SAMPLE_W'(a1);
        r.axes[2]      = SAMPLE_W'(a2);
        r.axes[3]      = SAMPLE_W'(a3);
        r.axis_count   = CNT_W'(n_axes);
        r.button_bits  = BTN_FIELDS'(bits);
        r.button_count = CNT_W'(n_btns);
        return r;
    endfunction

    function automatic t_smooth_result make_result(input int m0, input int m1, input int m2,
                                                   input int m3, input int held, input int r0,
                                                   input int r1, input int r2, input int r3,
                                                   input int r4);
        t_smooth_result s;
        s.means[0]    = SAMPLE_W'(m0);
        s.means[1]    = SAMPLE_W'(m1);
        s.means[2]    = SAMPLE_W'(m2);
        s.means[3]    = SAMPLE_W'(m3);
        s.held        = BTN_FIELDS'(held);
        s.releases[0] = REL_W'(r0);
        s.releases[1] = REL_W'(r1);
        s.releases[2] = REL_W'(r2);
        s.releases[3] = REL_W'(r3);
        s.releases[4] = REL_W'(r4);
        return s;
    endfunction

    // Applies one report to the shadow state and returns the result it should produce.
    function automatic t_smooth_result advance_smoother(input t_report rpt);
        t_smooth_result res;
        int             n_axes;
        int             n_btns;
        int             total;
        logic           level;
        logic           prior;
        n_axes = (rpt.axis_count > AXES) ? AXES : int'(rpt.axis_count);
        n_btns = (rpt.button_count > BUTTONS) ? BUTTONS : int'(rpt.button_count);

        // Each valid sample overwrites the oldest slot of its axis window.
        for (int a = 0; a < n_axes; a++) begin
            window_samples[a][window_next[a]] = $signed(rpt.axes[a]);
            window_next[a] = (window_next[a] + 1) % WIN_LEN;
            if (window_fill[a] < WIN_LEN) begin
                window_fill[a]++;
            end
        end

        // A press sets the held flag; a release clears it and counts.
        for (int b = 0; b < n_btns; b++) begin
            level = rpt.button_bits[b];
            prior = prev_levels[b];
            if (!prior && level) begin
                held_flags[b] = 1'b1;
            end else if (prior && !level) begin
                held_flags[b] = 1'b0;
                release_tally[b] = release_tally[b] + 1'b1;
            end
            prev_levels[b] = level;
        end

        // Mean over the filled entries, truncated toward zero; zero for an empty axis.
        res = '0;
        for (int a = 0; a < AXES; a++) begin
            if (window_fill[a] != 0) begin
                total = 0;
                for (int k = 0; k < window_fill[a]; k++) begin
                    total = total + window_samples[a][k];
                end
                res.means[a] = SAMPLE_W'(total / window_fill[a]);
            end
        end
        res.held = held_flags;
        for (int b = 0; b < BUTTONS; b++) begin
            res.releases[b] = release_tally[b];
        end
        return res;
    endfunction

    // Random sample with the extremes and the values around zero favored.
    function automatic int random_sample();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(0, 1) ? 0 : -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Presents one report, holds it until the beat is taken, then queues its result.
    task automatic send_report(input t_report rpt, input logic typed,
                               input t_smooth_result typed_want);
        t_smooth_result predicted;
        i_valid        <= 1'b1;
        i_axis_0       <= rpt.axes[0];
        i_axis_1       <= rpt.axes[1];
        i_axis_2       <= rpt.axes[2];
        i_axis_3       <= rpt.axes[3];
        i_axis_count   <= rpt.axis_count;
        i_button_bits  <= rpt.button_bits;
        i_button_count <= rpt.button_count;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predicted = advance_smoother(rpt);
        pending_results.insert(pending_results.size(), typed ? typed_want : predicted);
    endtask

    // Sender works in bursts; between bursts it may drop valid for a while.
    task automatic pace_sender();
        int gap_len;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 30);
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_len > 0) begin
                i_valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end
    endtask

    // Stimulus: reset, the directed table, random reports, then drain.
    initial begin : stimulus
        t_report_row opening_reports [$];
        t_report     rpt;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_axis_0       <= '0;
        i_axis_1       <= '0;
        i_axis_2       <= '0;
        i_axis_3       <= '0;
        i_axis_count   <= '0;
        i_button_bits  <= '0;
        i_button_count <= '0;

        // Empty report straight after reset, then oversized counts at the extremes.
        opening_reports.push_back('{make_report(0, 0, 0, 0, 0, 0, 0), 1'b1,
                                    make_result(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        opening_reports.push_back('{make_report(32767, -32768, 21845, -21846, 7, 31, 7), 1'b1,
                                    make_result(32767, -32768, 21845, -21846, 31,
                                                0, 0, 0, 0, 0)});
        opening_reports.push_back('{make_report(0, 0, 0, 0, 0, 0, 5), 1'b1,
                                    make_result(32767, -32768, 21845, -21846, 0,
                                                1, 1, 1, 1, 1)});
        opening_reports.push_back('{make_report(32767, 32767, 32767, 32767, 4, 0, 0), 1'b0,
                                    '0});
        // Axis 0 alone, enough samples to wrap its window.
        opening_reports.push_back('{make_report(-32768, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        opening_reports.push_back('{make_report(1, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        opening_reports.push_back('{make_report(-1, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        opening_reports.push_back('{make_report(12345, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        opening_reports.push_back('{make_report(-9999, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        opening_reports.push_back('{make_report(-32768, -32768, 7, 7, 2, 0, 0), 1'b0, '0});
        opening_reports.push_back('{make_report(32767, 32767, 32767, 5, 3, 0, 0), 1'b0, '0});
        // Button levels beyond the valid count must be ignored.
        opening_reports.push_back('{make_report(0, 0, 0, 0, 0, 31, 0), 1'b0, '0});
        opening_reports.push_back('{make_report(0, 0, 0, 0, 0, 31, 1), 1'b0, '0});
        opening_reports.push_back('{make_report(0, 0, 0, 0, 0, 26, 3), 1'b0, '0});
        opening_reports.push_back('{make_report(0, 0, 0, 0, 0, 5, 4), 1'b0, '0});
        opening_reports.push_back('{make_report(0, 0, 0, 0, 0, 16, 6), 1'b0, '0});
        opening_reports.push_back('{make_report(-300, 400, -500, 600, 5, 15, 5), 1'b0, '0});
        opening_reports.push_back('{make_report(1000, -2000, 3000, -4000, 6, 0, 2), 1'b0, '0});
        // Full windows of one extreme, then the other.
        for (int i = 0; i < 2 * WIN_LEN; i++) begin
            rpt = (i < WIN_LEN) ? make_report(-32768, -32768, -32768, -32768, 4, 0, 0)
                                : make_report(32767, 32767, 32767, 32767, 4, 0, 0);
            opening_reports.push_back('{rpt, 1'b0, '0});
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_reports[i]) begin
            send_report(opening_reports[i].rpt, opening_reports[i].typed,
                        opening_reports[i].want);
            pace_sender();
        end

        // Random reports: mostly in-range counts, with oversized ones mixed in.
        for (int n = 0; n < RANDOM_REPORTS; n++) begin
            for (int a = 0; a < AXIS_FIELDS; a++) begin
                rpt.axes[a] = SAMPLE_W'(random_sample());
            end
            rpt.axis_count   = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(5, 7))
                                                           : CNT_W'($urandom_range(0, 4));
            rpt.button_bits  = BTN_FIELDS'($urandom_range(0, 31));
            rpt.button_count = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 7))
                                                           : CNT_W'(BUTTONS);
            send_report(rpt, 1'b0, '0);
            pace_sender();
        end
        i_valid <= 1'b0;

        // Drain, then give a stray beat time to show up.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver back-pressure: a new style is picked at random each time flow_cycles wraps.
    always @(posedge i_clk) begin
        if (flow_cycles == 63) begin
            flow_cycles <= 0;
            flow_mode   <= t_flow_mode'($urandom_range(0, 3));
        end else begin
            flow_cycles <= flow_cycles + 1;
        end
        case (flow_mode)
            FLOW_FREE:     i_stall <= 1'b0;
            FLOW_COIN:     i_stall <= 1'($urandom_range(0, 1));
            FLOW_CHOKED:   i_stall <= ($urandom_range(0, 3) != 0);
            FLOW_PERIODIC: i_stall <= (flow_cycles % 3 == 0);
        endcase
    end

    // Compare every taken result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_smooth_result got;
        t_smooth_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_mean_3, o_mean_2, o_mean_1, o_mean_0, o_held_mask,
                   o_releases_4, o_releases_3, o_releases_2, o_releases_1, o_releases_0};
            if (pending_results.size() == 0) begin
                note_mismatch("result beat with no report pending");
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                for (int a = 0; a < AXIS_FIELDS; a++) begin
                    if (got.means[a] !== want.means[a]) begin
                        note_mismatch($sformatf("mean_%0d: expected %0d, got %0d", a,
                                                $signed(want.means[a]),
                                                $signed(got.means[a])));
                    end
                end
                if (got.held !== want.held) begin
                    note_mismatch($sformatf("held_mask: expected %b, got %b",
                                            want.held, got.held));
                end
                for (int b = 0; b < BTN_FIELDS; b++) begin
                    if (got.releases[b] !== want.releases[b]) begin
                        note_mismatch($sformatf("releases_%0d: expected %0d, got %0d", b,
                                                want.releases[b], got.releases[b]));
                    end
                end
            end
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/cis_pkg.sv
hw/rtl/cis_axis_lane.sv
hw/rtl/cis_buttons.sv
hw/rtl/controller_input_smoother.sv
hw/rtl/cis_checker.sv
verif/controller_input_smoother_test.sv
